[sv/murmur3_32_stream_hash_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the MurmurHash3 stream hasher
// Implication checks, clocked and disabled in reset, that compile to nothing
// when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef MURMUR3_32_STREAM_HASH_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define M3H_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define M3H_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define M3H_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define M3H_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[sv/m3h_pkg.sv]
// ---------------------------------------------------------------------------
// m3h_pkg
// Constants, queue entry type and helpers shared by the hasher modules.
// ---------------------------------------------------------------------------
package m3h_pkg;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [2:0] FULL_COUNT = 3'd4;

  // scrambled word, effective byte count (0..4), end of message
  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  count;
    logic        last;
  } entry_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    rotl32 = (v << s) | (v >> (32 - s));
  endfunction

endpackage

[sv/m3h_channels.sv]
// ---------------------------------------------------------------------------
// Stream channels
// Valid/ready channels carrying input words and finished hashes.
// ---------------------------------------------------------------------------
interface hash_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_item;

  modport source (output valid, data_word, byte_count, last_item, input ready);
  modport sink   (input valid, data_word, byte_count, last_item, output ready);
endinterface

interface hash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

[sv/m3h_front.sv]
// ---------------------------------------------------------------------------
// m3h_front
// Accepts words, masks tails, fixes the byte count and scrambles the word
// in a two-stage multiply pipeline feeding the queue.
// ---------------------------------------------------------------------------
module m3h_front (
  input  logic              clk,
  input  logic              rst,
  hash_in_if.sink           words,
  output logic              push_valid,
  input  logic              push_ready,
  output m3h_pkg::entry_t   push_entry
);

  logic        s1_valid;
  logic [31:0] s1_k;
  logic [2:0]  s1_count;
  logic        s1_last;
  logic        s2_valid;
  logic [31:0] s2_k;
  logic [2:0]  s2_count;
  logic        s2_last;

  logic        s1_free;
  logic        s2_free;
  logic [2:0]  eff_count;
  logic [31:0] masked;

  assign s2_free     = !s2_valid || push_ready;
  assign s1_free     = !s1_valid || s2_free;
  assign words.ready = s1_free;

  always_comb begin
    if (!words.last_item || words.byte_count >= m3h_pkg::FULL_COUNT) begin
      eff_count = m3h_pkg::FULL_COUNT;
    end else begin
      eff_count = words.byte_count;
    end
    case (eff_count)
      3'd0:    masked = 32'h0;
      3'd1:    masked = {24'h0, words.data_word[7:0]};
      3'd2:    masked = {16'h0, words.data_word[15:0]};
      3'd3:    masked = {8'h0, words.data_word[23:0]};
      default: masked = words.data_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= words.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && words.valid) begin
      s1_k     <= 32'(masked * m3h_pkg::MIX_C1);
      s1_count <= eff_count;
      s1_last  <= words.last_item;
    end
    if (s2_free && s1_valid) begin
      s2_k     <= 32'(m3h_pkg::rotl32(s1_k, 15) * m3h_pkg::MIX_C2);
      s2_count <= s1_count;
      s2_last  <= s1_last;
    end
  end

  assign push_valid       = s2_valid;
  assign push_entry.k     = s2_k;
  assign push_entry.count = s2_count;
  assign push_entry.last  = s2_last;

endmodule

[sv/m3h_queue.sv]
// ---------------------------------------------------------------------------
// m3h_queue
// Short FIFO of scrambled words between front and back.
// ---------------------------------------------------------------------------
module m3h_queue #(
  parameter int unsigned DEPTH = m3h_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  m3h_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output m3h_pkg::entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  m3h_pkg::entry_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/m3h_back.sv]
// ---------------------------------------------------------------------------
// m3h_back
// Holds the seed and running hash, mixes queued words and runs the
// finalizer (states ST_FIN0, ST_FIN1, ST_FIN2) into the output register.
// ---------------------------------------------------------------------------
`include "murmur3_32_stream_hash_assert.svh"

module m3h_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  m3h_pkg::entry_t pop_entry,
  hash_out_if.source      hashes
);

  typedef enum logic [1:0] {ST_RUN, ST_FIN0, ST_FIN1, ST_FIN2} state_t;

  state_t      state;
  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] byte_length;
  logic        msg_start;
  logic [31:0] fin;
  logic        out_valid;
  logic [31:0] out_hash;

  logic        pop;
  logic        slot_free;
  logic [31:0] h_base;
  logic [31:0] len_base;
  logic [31:0] h_xor;
  logic [31:0] h_rot;
  logic [31:0] hash_next;
  logic [31:0] length_next;
  logic [31:0] x0;
  logic [31:0] x1;

  assign pop_ready = state == ST_RUN;
  assign pop       = pop_valid && pop_ready;
  assign slot_free = !out_valid || hashes.ready;

  always_comb begin
    h_base      = msg_start ? seed : running_hash;
    len_base    = msg_start ? 32'h0 : byte_length;
    h_xor       = h_base ^ pop_entry.k;
    h_rot       = m3h_pkg::rotl32(h_xor, 13);
    hash_next   = pop_entry.count[2] ? ((h_rot << 2) + h_rot + m3h_pkg::MIX_ADD) : h_xor;
    length_next = len_base + {29'h0, pop_entry.count};
    x0          = running_hash ^ byte_length;
    x1          = fin ^ (fin >> 13);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      seed         <= 32'h0;
      running_hash <= 32'h0;
      byte_length  <= 32'h0;
      msg_start    <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      if (state == ST_FIN2 && slot_free) begin
        out_valid <= 1'b1;
      end else if (hashes.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (pop) begin
            running_hash <= hash_next;
            byte_length  <= length_next;
            msg_start    <= 1'b0;
            if (pop_entry.last) begin
              state <= ST_FIN0;
            end
          end
        end
        ST_FIN0: begin
          fin   <= 32'((x0 ^ (x0 >> 16)) * m3h_pkg::FIN_C1);
          state <= ST_FIN1;
        end
        ST_FIN1: begin
          fin   <= 32'(x1 * m3h_pkg::FIN_C2);
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          if (slot_free) begin
            out_hash  <= fin ^ (fin >> 16);
            msg_start <= 1'b1;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign hashes.valid      = out_valid;
  assign hashes.hash_value = out_hash;

  `M3H_ASSERT_IMPL(a_pop_in_run, clk, rst, pop, state == ST_RUN, "pop outside run state")
  `M3H_ASSERT_NEXT(a_last_fin, clk, rst, pop && pop_entry.last, state == ST_FIN0, "last not finalized")
  `M3H_ASSERT_NEXT(a_fin_seq, clk, rst, state == ST_FIN0, state == ST_FIN1, "finalizer out of order")
  `M3H_ASSERT_NEXT(a_emit, clk, rst, state == ST_FIN2 && slot_free, out_valid && msg_start && state == ST_RUN, "hash not emitted")

endmodule

[sv/murmur3_32_stream_hash.sv]
// ---------------------------------------------------------------------------
// murmur3_32_stream_hash
// MurmurHash3 x86_32 over a stream of little-endian words with seed register.
// ---------------------------------------------------------------------------
// Path from last word accepted to hash valid: 2 scramble stages (s1, s2), the
// queue, then the finalizer states ST_FIN0..ST_FIN2 in the back end.
// Throughput: one word per cycle while the queue has room; the back end stops
// popping while it finalizes a message; the queue absorbs short bursts.
// Reset: seed and running state cleared, queue and pipeline emptied; no sweep.
module murmur3_32_stream_hash #(
  parameter int unsigned QUEUE_DEPTH = m3h_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  hash_in_if.sink     words,
  hash_out_if.source  hashes
);

  logic            push_valid;
  logic            push_ready;
  m3h_pkg::entry_t push_entry;
  logic            pop_valid;
  logic            pop_ready;
  m3h_pkg::entry_t pop_entry;

  m3h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .words      (words),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  m3h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  m3h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .hashes    (hashes)
  );

endmodule

[bench/murmur3_32_stream_hash_checker.sv]
// ---------------------------------------------------------------------------
// MurmurHash3 stream hasher checker
// Watches the seed port and both channels and predicts the finalised hash of
// each message from the accepted words. Compares every hash transaction with
// the oldest predicted hash. Reports the number of mismatches and the number
// of hashes still due.
// ---------------------------------------------------------------------------
module murmur3_32_stream_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        word_valid,
  input  logic        word_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  input  logic        hash_valid,
  input  logic        hash_ready,
  input  logic [31:0] hash_value,
  output int          mismatches,
  output int          hashes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] K_MUL1  = 32'hcc9e2d51;
  localparam logic [31:0] K_MUL2  = 32'h1b873593;
  localparam logic [31:0] H_ADD   = 32'he6546b64;
  localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
  localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;

  logic [31:0] seed_reg;
  logic [31:0] run_hash;
  logic [31:0] msg_bytes;
  logic        msg_fresh;
  logic [31:0] want_hash;
  logic [2:0]  eff_count;
  logic [31:0] tail_mask;
  logic [31:0] hash_due_q[$];
  int          err_count;

  function automatic logic [31:0] scramble_k(input logic [31:0] k);
    logic [31:0] t;
    t = k * K_MUL1;
    t = {t[16:0], t[31:17]};
    return t * K_MUL2;
  endfunction

  function automatic logic [31:0] finalise_hash(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * FMIX_M1;
    t = t ^ (t >> 13);
    t = t * FMIX_M2;
    return t ^ (t >> 16);
  endfunction

  initial begin
    err_count  = 0;
    mismatches = 0;
    hashes_due = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      seed_reg  = '0;
      run_hash  = '0;
      msg_bytes = '0;
      msg_fresh = 1'b1;
      hash_due_q.delete();
    end else begin
      if (hash_valid && hash_ready) begin
        if (hash_due_q.size() == 0) begin
          $display("%0t: hash transaction with none due: expected none, got %h",
                   $time, hash_value);
          err_count++;
        end else begin
          want_hash = hash_due_q.pop_front();
          if (hash_value !== want_hash) begin
            $display("%0t: hash_value mismatch: expected %h, got %h",
                     $time, want_hash, hash_value);
            err_count++;
          end
        end
      end
      if (word_valid && word_ready) begin
        if (msg_fresh) begin
          run_hash  = seed_reg;
          msg_bytes = '0;
          msg_fresh = 1'b0;
        end
        eff_count = (!last_item || byte_count >= 3'd4) ? 3'd4 : byte_count;
        if (eff_count == 3'd4) begin
          run_hash = run_hash ^ scramble_k(data_word);
          run_hash = {run_hash[18:0], run_hash[31:19]};
          run_hash = run_hash * 32'd5 + H_ADD;
        end else if (eff_count != 3'd0) begin
          tail_mask = 32'hffffffff >> (8 * (4 - int'(eff_count)));
          run_hash  = run_hash ^ scramble_k(data_word & tail_mask);
        end
        msg_bytes = msg_bytes + {29'd0, eff_count};
        if (last_item) begin
          hash_due_q.push_back(finalise_hash(run_hash ^ msg_bytes));
          msg_fresh = 1'b1;
        end
      end
      // seed is taken at the next message start
      if (cfg_we) begin
        seed_reg = cfg_wdata;
      end
    end
    hashes_due <= hash_due_q.size();
    mismatches <= err_count;
  end

endmodule

[bench/murmur3_32_stream_hash_test.sv]
// ---------------------------------------------------------------------------
// MurmurHash3 stream hasher testbench
// Drives word transactions and seed writes into the hasher with random gaps
// and back-pressure. Starts with directed messages covering tails, empty
// messages and odd byte counts, then runs random messages under several
// seeds. The checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module murmur3_32_stream_hash_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_WORDS   = 150;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        calm = 1'b0;
  int unsigned cycles = 0;
  int          mismatches;
  int          hashes_due;

  hash_in_if  words ();
  hash_out_if hashes ();

  murmur3_32_stream_hash i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .words     (words),
    .hashes    (hashes)
  );

  murmur3_32_stream_hash_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .word_valid (words.valid),
    .word_ready (words.ready),
    .data_word  (words.data_word),
    .byte_count (words.byte_count),
    .last_item  (words.last_item),
    .hash_valid (hashes.valid),
    .hash_ready (hashes.ready),
    .hash_value (hashes.hash_value),
    .mismatches (mismatches),
    .hashes_due (hashes_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      words.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    words.valid      <= 1'b1;
    words.data_word  <= data;
    words.byte_count <= count;
    words.last_item  <= last;
    do @(posedge clk); while (!words.ready);
    @(negedge clk);
  endtask

  task automatic load_seed(input logic [31:0] seed);
    words.valid <= 1'b0;
    while (hashes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_message();
    int unsigned pick;
    int unsigned n_words;
    logic [2:0]  count;
    pick = $urandom_range(0, 9);
    if (pick < 7) n_words = $urandom_range(1, 4);
    else if (pick < 9) n_words = $urandom_range(5, 16);
    else n_words = $urandom_range(17, 64);
    for (int unsigned i = 1; i < n_words; i++) begin
      count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, count, 1'b0);
    end
    count = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    send_word($urandom, count, 1'b1);
  endtask

  // hash sink back-pressure
  initial begin
    int unsigned stall;
    hashes.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        hashes.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hashes.ready <= 1'b1;
      do @(posedge clk); while (!hashes.valid);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned sent;
    logic [31:0] seed;
    words.valid      = 1'b0;
    words.data_word  = '0;
    words.byte_count = '0;
    words.last_item  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // seed at its reset value
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h12345678, 3'd5, 1'b1);
    send_word(32'h9abcdef0, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h01020304, 3'd0, 1'b0);
    send_word(32'hfedcba98, 3'd3, 1'b0);
    send_word(32'h55aa55aa, 3'd7, 1'b0);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'h61626364, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd0, 1'b1);

    load_seed(32'hffffffff);
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'h00000000, 3'd1, 1'b1);
    send_word(32'h80000000, 3'd4, 1'b0);
    send_word(32'h00000001, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: seed = 32'h00000000;
        1: seed = 32'hffffffff;
        3: seed = 32'h80000000;
        4: seed = 32'h00000001;
        default: seed = $urandom;
      endcase
      load_seed(seed);
      calm = (phase == 2 || phase == 6);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        send_message();
        sent = i_sent_words_note(sent);
      end
    end
    calm = 1'b0;

    words.valid <= 1'b0;
    while (hashes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // word transactions accepted so far, used to pace each phase
  int unsigned words_taken = 0;
  always @(posedge clk) begin
    if (words.valid && words.ready) words_taken <= words_taken + 1;
  end

  int unsigned phase_base = 0;
  function automatic int unsigned i_sent_words_note(input int unsigned sent);
    if (sent == 0) phase_base = words_taken;
    return words_taken - phase_base + 1;
  endfunction

endmodule

[murmur3_32_stream_hash.f]
+incdir+sv
sv/m3h_pkg.sv
sv/m3h_channels.sv
sv/m3h_front.sv
sv/m3h_queue.sv
sv/m3h_back.sv
sv/murmur3_32_stream_hash.sv
bench/murmur3_32_stream_hash_checker.sv
bench/murmur3_32_stream_hash_test.sv
